### hw/rtl/lurs_pkg.sv
// Package: types and constants shared by the largest usable region selector.
`default_nettype none
package lurs_pkg;

	// Page size for base round-up; must be a power of two.
	localparam int unsigned PAGE_BYTES = 4096;
	localparam logic [32:0] PAGE_ADD  = 33'(PAGE_BYTES - 1);
	localparam logic [32:0] PAGE_MASK = ~PAGE_ADD;

	localparam logic [31:0] TOP_ADDR = 32'hFFFF_FFFF;

	// Register map (word index = paddr[3:2])
	localparam int unsigned PADDR_W = 4;
	localparam logic [1:0] REG_EXT_ATTR = 2'd0;
	localparam logic [1:0] REG_USABLE_TYPE = 2'd1;
	localparam logic [1:0] REG_LOWEST_USABLE = 2'd2;

	localparam logic [31:0] RST_USABLE_TYPE = 32'd1;
	localparam logic [31:0] RST_LOWEST_USABLE = 32'h0020_0000;

	// Input word: one memory map entry
	typedef struct packed {
		logic [63:0] base_address;
		logic [63:0] region_length;
		logic [31:0] region_type;
		logic [31:0] attribute_flags;
		logic        last_entry;
	} lurs_entry_t;

	// Output word: the chosen region
	typedef struct packed {
		logic        found;
		logic [31:0] best_base;
		logic [32:0] best_length;
		logic [31:0] best_flags;
	} lurs_result_t;

	// Configuration seen by the front
	typedef struct packed {
		logic        ext_attr_present;
		logic [31:0] usable_type;
		logic [31:0] lowest_usable;
	} lurs_cfg_t;

	// Classified entry passed from front to back
	typedef struct packed {
		logic        usable;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] flags;
		logic        last;
	} lurs_cand_t;

endpackage
`default_nettype wire

### hw/rtl/largest_usable_region_select.sv
// Largest usable region selector: the APB registers, front, queue and back.
//
// Memory map entries arrive on entry/entry_valid/entry_stall, one word per
// cycle while not stalled. Each entry is filtered by type (and enable/volatile
// bits when extended attributes are on), rounded up to a page, clipped to
// lowest_usable..4 GiB-1, and the largest region is kept; a tie keeps the
// earlier one. When an entry with last_entry set has been processed, one word
// appears on result/result_valid/result_stall and the kept region is cleared.
// A result is registered after its last entry is accepted, passing the front
// register, then the queue, then the back into the output register.
// Throughput: one entry per cycle while not stalled; the front add/clip and the
// back subtract/compare are each combinational into a register.
// A stalled result holds in the output register; further non-last entries
// keep flowing, and entries back up through the two-entry queue only when a
// second last entry reaches the back before the first result is taken.
// Reset clears the kept region and all valids and loads the register
// defaults: ext_attr_present 0, usable_type 1, lowest_usable 0x200000.
// Registers lie at byte addresses 0, 4 and 8; pready is always high.
`default_nettype none
module largest_usable_region_select
	import lurs_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               entry_valid,
	output logic                    entry_stall,
	input  wire lurs_entry_t        entry,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output lurs_result_t            result
);

	logic        ext_attr_q;
	logic [31:0] usable_type_q;
	logic [31:0] lowest_usable_q;
	lurs_cfg_t   cfg;
	logic        wr_en;
	logic        push;
	lurs_cand_t  push_cand;
	logic        q_ready;
	logic        pop;
	logic        head_valid;
	lurs_cand_t  head;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_attr_q <= 1'b0;
			usable_type_q <= RST_USABLE_TYPE;
			lowest_usable_q <= RST_LOWEST_USABLE;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_EXT_ATTR: ext_attr_q <= pwdata[0];
				REG_USABLE_TYPE: usable_type_q <= pwdata;
				REG_LOWEST_USABLE: lowest_usable_q <= pwdata;
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (paddr[3:2])
			REG_EXT_ATTR: prdata = {31'd0, ext_attr_q};
			REG_USABLE_TYPE: prdata = usable_type_q;
			REG_LOWEST_USABLE: prdata = lowest_usable_q;
			default: prdata = 32'd0;
		endcase
	end

	assign cfg.ext_attr_present = ext_attr_q;
	assign cfg.usable_type = usable_type_q;
	assign cfg.lowest_usable = lowest_usable_q;

	lurs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.entry_valid (entry_valid),
		.entry_stall (entry_stall),
		.entry       (entry),
		.push        (push),
		.push_cand   (push_cand),
		.q_ready     (q_ready)
	);

	lurs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cand  (push_cand),
		.ready      (q_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	lurs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
`default_nettype wire

### hw/rtl/lurs_front.sv
// Front: accepts entries, filters and clips them into candidate ranges.
`default_nettype none
module lurs_front
	import lurs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire lurs_cfg_t   cfg,
	input  wire logic        entry_valid,
	output logic             entry_stall,
	input  wire lurs_entry_t entry,
	output logic             push,
	output lurs_cand_t       push_cand,
	input  wire logic        q_ready
);

	logic        s1_valid_q;
	lurs_cand_t  cand_s1;
	logic        advance;
	logic        type_ok;
	logic        attr_ok;
	logic        base_ok;
	logic [63:0] end_addr;
	logic [31:0] hi;
	logic [32:0] lo_pg;
	logic [32:0] lo;
	logic        nonempty;
	lurs_cand_t  cand;

	// Handshake: stage holds until the queue takes it
	assign push = s1_valid_q && q_ready;
	assign advance = !s1_valid_q || q_ready;
	assign entry_stall = !advance;
	assign push_cand = cand_s1;

	// Classify and clip
	always_comb begin
		type_ok = (entry.region_type == cfg.usable_type);
		attr_ok = !cfg.ext_attr_present ||
			(entry.attribute_flags[0] && !entry.attribute_flags[1]);
		base_ok = (entry.base_address[63:32] == 32'd0);
		end_addr = entry.base_address + entry.region_length - 64'd1;
		hi = (end_addr[63:32] != 32'd0) ? TOP_ADDR : end_addr[31:0];
		lo_pg = ({1'b0, entry.base_address[31:0]} + PAGE_ADD) & PAGE_MASK;
		lo = (lo_pg < {1'b0, cfg.lowest_usable}) ? {1'b0, cfg.lowest_usable} : lo_pg;
		nonempty = (lo <= {1'b0, hi});
		cand.usable = type_ok && attr_ok && base_ok && nonempty;
		cand.lo = lo[31:0];
		cand.hi = hi;
		cand.flags = entry.attribute_flags;
		cand.last = entry.last_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (advance) begin
			s1_valid_q <= entry_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && entry_valid) begin
			cand_s1 <= cand;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/lurs_queue.sv
// Two-entry queue decoupling the front from the back.
`default_nettype none
module lurs_queue
	import lurs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire lurs_cand_t push_cand,
	output logic            ready,
	input  wire logic       pop,
	output logic            head_valid,
	output lurs_cand_t      head
);

	lurs_cand_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign ready = (count_q != 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cand;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/lurs_back.sv
// Back: sizes candidates, keeps the largest, emits the winner on the last entry.
`default_nettype none
module lurs_back
	import lurs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       head_valid,
	input  wire lurs_cand_t head,
	output logic            pop,
	output logic            result_valid,
	input  wire logic       result_stall,
	output lurs_result_t    result
);

	logic [31:0]  kept_base_q;
	logic [32:0]  kept_length_q;
	logic [31:0]  kept_flags_q;
	logic         out_valid_q;
	lurs_result_t out_q;
	logic [32:0]  size;
	logic         better;
	logic [31:0]  nxt_base;
	logic [32:0]  nxt_length;
	logic [31:0]  nxt_flags;

	// A last entry waits for a free output register
	assign pop = head_valid && (!head.last || !out_valid_q || !result_stall);
	assign result_valid = out_valid_q;
	assign result = out_q;

	// Size and strict-greater compare
	always_comb begin
		size = {1'b0, head.hi} - {1'b0, head.lo} + 33'd1;
		better = head.usable && (size > kept_length_q);
		nxt_base = better ? head.lo : kept_base_q;
		nxt_length = better ? size : kept_length_q;
		nxt_flags = better ? head.flags : kept_flags_q;
	end

	// Kept region and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_base_q <= 32'd0;
			kept_length_q <= 33'd0;
			kept_flags_q <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (head.last) begin
					kept_base_q <= 32'd0;
					kept_length_q <= 33'd0;
					kept_flags_q <= 32'd0;
				end else begin
					kept_base_q <= nxt_base;
					kept_length_q <= nxt_length;
					kept_flags_q <= nxt_flags;
				end
			end
			if (pop && head.last) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output word
	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			out_q.found <= (nxt_length != 33'd0);
			out_q.best_base <= nxt_base;
			out_q.best_length <= nxt_length;
			out_q.best_flags <= nxt_flags;
		end
	end

endmodule
`default_nettype wire
